// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl of the positional list
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge, reset not masked
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only while reset is released
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ----- rtl/core/pli_pkg.sv -----
// package of the positional list: types, codes and defaults
`default_nettype none
package pli_pkg;

  localparam int unsigned PLI_DEPTH = 32;
  localparam int unsigned PLI_SLOT_W = 6;
  localparam int unsigned PLI_POS_W = 7;
  localparam int unsigned PLI_WORD_W = 32;

  typedef logic signed [PLI_WORD_W-1:0] word_t;
  typedef logic [PLI_SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e op;
    slot_t    sel;   // slot of insert or delete
    slot_t    lim;   // last occupied slot for rotate
    word_t    data;  // inserted word or wrapped head word
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/pli_if.sv -----
// request and response channel interfaces of the positional list
`default_nettype none
interface pli_req_if;
  import pli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [PLI_POS_W-1:0] position;
  word_t                value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink (input valid, req_type, position, value, output ready);
endinterface

interface pli_rsp_if;
  import pli_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  word_t      element;
  slot_t      slot;
  logic       last;

  modport source (output valid, status, element, slot, last, input ready);
  modport sink (input valid, status, element, slot, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pli_cell.sv -----
// one storage cell of the shifting word chain
`default_nettype none
module pli_cell import pli_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire logic      clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire word_t     left_i,
  input  wire word_t     right_i,
  output word_t          data_o
);

  localparam slot_t MyIdx = PLI_SLOT_W'(IDX);

  word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (MyIdx == ctl_i.sel) begin
          data_d = ctl_i.data;
        end else if (MyIdx > ctl_i.sel) begin
          data_d = left_i;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= ctl_i.sel) begin
          data_d = right_i;
        end
      end
      OP_ROTATE: begin
        if (MyIdx == ctl_i.lim) begin
          data_d = ctl_i.data;
        end else if (MyIdx < ctl_i.lim) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- rtl/core/positional_list_insert_delete.sv -----
// positional list: insert and delete answer in the cycle after the request transfer
// dump of n words: the transfer enters the dump state, which then registers one word per cycle
// while the response register is free or being drained; requests stay closed until the dump returns to idle
// insert and delete shift the cells from the selected slot on in the accept cycle, result registered next cycle
// in idle, a new request is taken each cycle while the response register is free or being drained
// a dump rotates the chain left once per emitted word, so count rotations restore the order
// reset clears the element count and the response register, the stored words stay undefined
`default_nettype none
`include "assert_macros.svh"
module positional_list_insert_delete import pli_pkg::*; #(
  parameter int unsigned DEPTH = PLI_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pli_req_if.sink   req_i,
  pli_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] dmp_q, dmp_d;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  word_t           element_q, element_d;
  slot_t           slot_q, slot_d;
  logic            last_q, last_d;

  cell_ctl_t ctl;
  word_t     cells [DEPTH];

  // the chain of cells, each one takes its left or right neighbor on a shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_body
      assign right_w = cells[g+1];
    end
    pli_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cells[g])
    );
  end

  logic                 out_free;
  logic                 req_take;
  logic [PLI_POS_W-1:0] pos_m1;
  logic [IdxW-1:0]      sel_idx;
  logic [7:0]           pos_x, cnt_x;
  logic                 is_full, is_empty, ins_ok, del_ok, dmp_last;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign req_take = req_i.valid && req_i.ready;

  // position checks: insert takes 1..count+1, delete takes 1..count
  assign pos_m1   = req_i.position - PLI_POS_W'(1);
  assign sel_idx  = pos_m1[IdxW-1:0];
  assign pos_x    = 8'(req_i.position);
  assign cnt_x    = 8'(cnt_q);
  assign is_full  = (cnt_q == CntW'(DEPTH));
  assign is_empty = (cnt_q == '0);
  assign ins_ok   = (req_i.position != '0) && (pos_x <= cnt_x + 8'd1);
  assign del_ok   = (req_i.position != '0) && (pos_x <= cnt_x);
  assign dmp_last = (CntW'(dmp_q) + CntW'(1) == cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dmp_d       = dmp_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    element_d   = element_q;
    slot_d      = slot_q;
    last_d      = last_q;
    ctl         = '{op: OP_HOLD, sel: '0, lim: '0, data: '0};

    unique case (state_q)
      S_IDLE: begin
        if (req_take) begin
          // single answers close the transfer; only a successful delete carries an element and slot
          element_d = '0;
          slot_d    = '0;
          last_d    = 1'b1;
          case (req_i.req_type)
            REQ_INSERT: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                status_d = ST_FULL;
              end else if (!ins_ok) begin
                status_d = ST_BADPOS;
              end else begin
                status_d = ST_OK;
                cnt_d    = cnt_q + CntW'(1);
                ctl      = '{op: OP_INSERT, sel: PLI_SLOT_W'(sel_idx), lim: '0,
                             data: req_i.value};
              end
            end
            REQ_DELETE: begin
              out_valid_d = 1'b1;
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else if (!del_ok) begin
                status_d = ST_BADPOS;
              end else begin
                status_d  = ST_OK;
                element_d = cells[sel_idx];
                slot_d    = PLI_SLOT_W'(sel_idx);
                cnt_d     = cnt_q - CntW'(1);
                ctl       = '{op: OP_DELETE, sel: PLI_SLOT_W'(sel_idx), lim: '0,
                              data: '0};
              end
            end
            REQ_DUMP: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                status_d    = ST_EMPTY;
              end else begin
                state_d = S_DUMP;
                dmp_d   = '0;
              end
            end
            default: begin
              // unknown request: no response, list untouched
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          // head word goes out and wraps to the last occupied slot
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          element_d   = cells[0];
          slot_d      = PLI_SLOT_W'(dmp_q);
          last_d      = dmp_last;
          ctl         = '{op: OP_ROTATE, sel: '0,
                          lim: PLI_SLOT_W'(cnt_q - CntW'(1)), data: cells[0]};
          dmp_d       = dmp_q + IdxW'(1);
          if (dmp_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dmp_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      element_q   <= '0;
      slot_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dmp_q       <= dmp_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      element_q   <= element_d;
      slot_q      <= slot_d;
      last_q      <= last_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.element = element_q;
  assign rsp_o.slot    = slot_q;
  assign rsp_o.last    = last_q;

  // count never exceeds the chain length
  `ASSERT_ALWAYS(a_cnt_bound, clk_i, cnt_q <= CntW'(DEPTH), "count above depth")
  // no request is taken while a dump walks the chain
  `ASSERT_RUN(a_dump_blocks, clk_i, rst_ni, state_q == S_DUMP |-> !req_i.ready,
              "request taken during dump")
  // count moves by at most one per cycle
  `ASSERT_RUN(a_cnt_step, clk_i, rst_ni,
              ##1 (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CntW'(1) ||
                   cnt_q + CntW'(1) == $past(cnt_q)), "count jumped")
  // a dump ends with a last-flagged transfer before the next request
  `ASSERT_RUN(a_dump_last, clk_i, rst_ni,
              (state_q == S_DUMP && state_d == S_IDLE) |=> (out_valid_q && last_q),
              "dump ended without last")

endmodule
`default_nettype wire
